FILE: design/pnra_pkg.sv
// Shared types and constants of the partial-network request aggregator.
package pnra_pkg;

    // Widths of the request, status and configuration fields.
    localparam int REQ_W        = 64;
    localparam int STATUS_W     = 64;
    localparam int RESET_TIME_W = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PN_RESET_TIME  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PN_ENABLE_MASK = 2'd1;

    // Token handed from cell to cell while a request walks the chain.
    typedef struct packed {
        logic active;
        logic changed;
    } pnra_tok_t;

endpackage

FILE: design/pnra_cell.sv
// One network cell: hold timer and status bit, updated as the token passes.
module pnra_cell #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pnra_pkg::pnra_tok_t    tok_in,
    input  logic                   req_bit,
    input  logic                   en_bit,
    input  logic [TIMER_WIDTH-1:0] reload,
    output pnra_pkg::pnra_tok_t    tok_out,
    output logic                   status_bit
);

    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic                   status_reg;
    logic                   status_next;
    pnra_pkg::pnra_tok_t    tok_reg;
    pnra_pkg::pnra_tok_t    tok_next;

    always_comb begin
        timer_next       = timer_reg;
        status_next      = status_reg;
        tok_next.active  = tok_in.active;
        tok_next.changed = tok_in.changed;
        if (tok_in.active && en_bit) begin
            if (req_bit) begin
                timer_next = reload;
                if (!status_reg) begin
                    status_next      = 1'b1;
                    tok_next.changed = 1'b1;
                end
            end
            // A running timer counts down; reaching zero drops the request.
            if (timer_next != '0) begin
                if (timer_next == TIMER_WIDTH'(1)) begin
                    status_next      = 1'b0;
                    tok_next.changed = 1'b1;
                end
                timer_next = timer_next - TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg  <= '0;
            status_reg <= 1'b0;
            tok_reg    <= '0;
        end else begin
            timer_reg  <= timer_next;
            status_reg <= status_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out    = tok_reg;
    assign status_bit = status_reg;

endmodule

FILE: design/pn_request_aggregator_top.sv
// Top level of the partial-network request aggregator: config, cell chain, result register.
// An accepted request passes the head token register, every network cell in turn, then the result register.
// The chain takes one request at a time; a token visits one network cell per cycle.
// A request produces a result only when some status bit changed; otherwise nothing is emitted.
// Reset (aresetn, synchronous, active low) clears all timers, status bits and both registers.
// No clearing pass is needed after reset; the block is ready in the first cycle.
module pn_request_aggregator_top #(
    parameter int NUM_NETWORKS = 64,
    parameter int TIMER_WIDTH  = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [pnra_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pnra_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Request channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pnra_pkg::REQ_W-1:0]         s_request_bits,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pnra_pkg::STATUS_W-1:0]      m_status_bits
);

    // Configuration registers.
    logic [pnra_pkg::RESET_TIME_W-1:0] pn_reset_time_reg;
    logic [NUM_NETWORKS-1:0]           pn_enable_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reset_time_reg  <= '0;
            pn_enable_mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                pnra_pkg::REG_PN_RESET_TIME: begin
                    pn_reset_time_reg <= cfg_wdata[pnra_pkg::RESET_TIME_W-1:0];
                end
                pnra_pkg::REG_PN_ENABLE_MASK: begin
                    pn_enable_mask_reg <= cfg_wdata[NUM_NETWORKS-1:0];
                end
                default: begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // The reload value is the reset time plus one, saturated at the largest timer value.
    // The sum needs one bit more than the reset time field.
    logic [pnra_pkg::RESET_TIME_W:0] reload_sum;
    logic [TIMER_WIDTH-1:0]          reload;

    assign reload_sum = {1'b0, pn_reset_time_reg} + (pnra_pkg::RESET_TIME_W + 1)'(1);

    generate
        if (TIMER_WIDTH > pnra_pkg::RESET_TIME_W) begin : g_reload_wide
            // The timer holds every possible sum, so no saturation is needed.
            assign reload = TIMER_WIDTH'(reload_sum);
        end else begin : g_reload_sat
            assign reload = (reload_sum[pnra_pkg::RESET_TIME_W:TIMER_WIDTH] != '0)
                          ? {TIMER_WIDTH{1'b1}}
                          : reload_sum[TIMER_WIDTH-1:0];
        end
    endgenerate

    // Handshake and control. The chain takes one request at a time; a new request is
    // taken only when the result register is free or being emptied, so the result of
    // the request in flight always finds room when it leaves the chain. No request is
    // taken while reset is asserted.
    logic                          busy_reg;
    logic                          s_accept;
    logic [NUM_NETWORKS-1:0]       req_reg;
    pnra_pkg::pnra_tok_t           tok_head_reg;
    logic                          m_valid_reg;
    logic [pnra_pkg::STATUS_W-1:0] m_status_bits_reg;

    assign s_ready  = aresetn && !busy_reg && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    // The request bits are held for the whole walk; each cell reads its own bit.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_request_bits[NUM_NETWORKS-1:0];
        end
    end

    // The token enters the first cell in the cycle after acceptance, with no change seen yet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_head_reg <= '0;
        end else begin
            tok_head_reg.active  <= s_accept;
            tok_head_reg.changed <= 1'b0;
        end
    end

    // The cell chain. Cell i handles network i and passes the token on to cell i + 1.
    pnra_pkg::pnra_tok_t     tok_chain [NUM_NETWORKS+1];
    logic [NUM_NETWORKS-1:0] cell_status;

    assign tok_chain[0] = tok_head_reg;

    generate
        for (genvar i = 0; i < NUM_NETWORKS; i++) begin : g_cell
            pnra_cell #(
                .TIMER_WIDTH (TIMER_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .tok_in     (tok_chain[i]),
                .req_bit    (req_reg[i]),
                .en_bit     (pn_enable_mask_reg[i]),
                .reload     (reload),
                .tok_out    (tok_chain[i+1]),
                .status_bit (cell_status[i])
            );
        end
    endgenerate

    // When the token leaves the last cell every status bit is final. Status bits of
    // positions beyond the configured networks read as zero.
    pnra_pkg::pnra_tok_t            tok_tail;
    logic [pnra_pkg::STATUS_W-1:0]  status_full;

    assign tok_tail = tok_chain[NUM_NETWORKS];

    always_comb begin
        status_full                   = '0;
        status_full[NUM_NETWORKS-1:0] = cell_status;
    end

    // Busy from acceptance until the token leaves the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_accept) begin
            busy_reg <= 1'b1;
        end else if (tok_tail.active) begin
            busy_reg <= 1'b0;
        end
    end

    // Result register: loaded only when the tick changed some status bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tok_tail.active && tok_tail.changed) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_tail.active && tok_tail.changed) begin
            m_status_bits_reg <= status_full;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status_bits = m_status_bits_reg;

endmodule
